// File: rtl/pips_pkg.sv
// Shared types and codes for the point-in-polygon select block.
// No dependencies; imported by point_in_polygon_select_top.
`timescale 1ns / 1ps
`default_nettype none

package pips_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_INVERT   = 3'd1,
    REG_BOX_LO_X = 3'd2,
    REG_BOX_HI_X = 3'd3,
    REG_BOX_LO_Y = 3'd4,
    REG_BOX_HI_Y = 3'd5
  } cfg_reg_t;

  // Request kinds carried in tuser bit 0
  localparam logic FUNC_VERTEX = 1'b0;
  localparam logic FUNC_POINT  = 1'b1;

  // Selection modes
  localparam logic MODE_BOX   = 1'b0;
  localparam logic MODE_LASSO = 1'b1;

  // Reset patterns of the box bounds, cut to the coordinate width
  localparam logic [31:0] BOX_LO_RST = 32'h0000_8000;
  localparam logic [31:0] BOX_HI_RST = 32'h0000_7FFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// File: rtl/point_in_polygon_select_top.sv
// Point-in-polygon select: box or lasso (crossing-number) point selection.
// Depends on pips_pkg (types, codes) and pips_ram (vertex store).
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | tuser {restart, func}, tdata {y, x}
//  m_*     | out | m_tvalid/m_tready | tdata {pad, truncated, selected}
//  cfg_*   | in  | cfg_we            | cfg_index, cfg_data (no read-back)
//
// Flow: a vertex request is a single RAM write. A box-mode point or a lasso
// point with fewer than two vertices goes straight from idle to emit. A
// lasso point walks the list: the walk reads one vertex per cycle from the
// single RAM read port, then drains a three-stage segment pipeline
// (compare, multiply, sum/sign) before the result is emitted.
// Reset (rst, synchronous) empties the vertex list and clears the overflow
// flag; the RAM contents are not cleared and only entries below the count
// are ever read.
// Stalls: one request is worked at a time; the output register lets a new
// request enter while the previous result waits for m_tready.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_select_top #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // input stream
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,  // coord_x, coord_y, pad
  input  wire logic [1:0]                             s_tuser,  // func, restart
  // result stream
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  output logic [7:0]                                  m_tdata,  // selected, truncated, pad
  // configuration
  input  wire logic                                   cfg_we,
  input  wire logic [pips_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [COORD_BITS-1:0]                  cfg_data
);

  import pips_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int D  = W + 1;              // coordinate difference
  localparam int P  = 2 * D;              // product
  localparam int S  = P + 1;              // sum of products
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                mode;
  logic                invert;
  logic signed [W-1:0] box_lo_x, box_hi_x, box_lo_y, box_hi_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_BOX;
      invert   <= 1'b0;
      box_lo_x <= BOX_LO_RST[W-1:0];
      box_hi_x <= BOX_HI_RST[W-1:0];
      box_lo_y <= BOX_LO_RST[W-1:0];
      box_hi_y <= BOX_HI_RST[W-1:0];
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:     mode     <= cfg_data[0];
        REG_INVERT:   invert   <= cfg_data[0];
        REG_BOX_LO_X: box_lo_x <= cfg_data;
        REG_BOX_HI_X: box_hi_x <= cfg_data;
        REG_BOX_LO_Y: box_lo_y <= cfg_data;
        REG_BOX_HI_Y: box_hi_y <= cfg_data;
        default: ;    // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic                in_acc;
  logic                req_func, req_restart;
  logic signed [W-1:0] req_x, req_y;

  assign in_acc      = s_tvalid && s_tready;
  assign req_func    = s_tuser[0];
  assign req_restart = s_tuser[1];
  assign req_x       = s_tdata[W-1:0];
  assign req_y       = s_tdata[2*W-1:W];

  // ---------------------------------------------------------------------------
  // State machine
  // ---------------------------------------------------------------------------
  state_t state, state_next;

  logic [CW-1:0] vcnt;          // stored vertex count
  logic          ovf;           // overflow flag
  logic [AW-1:0] rd_addr;       // walk read pointer
  logic [AW-1:0] last_addr;
  logic [CW-1:0] vcnt_m1;
  logic          rd_vld, rd_first;
  logic          s1_v, s2_v;
  logic          pipe_busy;
  logic          out_free;
  logic          rd_en;
  logic          emit;

  assign vcnt_m1   = vcnt - CW'(1);
  assign last_addr = vcnt_m1[AW-1:0];
  assign pipe_busy = rd_vld || s1_v || s2_v;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && req_func == FUNC_POINT) begin
          if (mode == MODE_BOX || vcnt < CW'(2)) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (rd_addr == last_addr) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    rd_en    = (state == ST_WALK);
    emit     = (state == ST_EMIT) && out_free;
  end

  // ---------------------------------------------------------------------------
  // Vertex store. Writes happen only in idle and reads only during a walk,
  // so the two ports never touch the same entry in one cycle.
  // ---------------------------------------------------------------------------
  logic          vtx_we;
  logic [CW-1:0] vtx_base;
  logic [2*W-1:0] rd_data;

  assign vtx_base = req_restart ? '0 : vcnt;
  assign vtx_we   = in_acc && (req_func == FUNC_VERTEX) &&
                    (vtx_base < CW'(MAX_VERTICES));

  pips_ram #(
    .WIDTH (2 * W),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (vtx_we),
    .waddr (vtx_base[AW-1:0]),
    .wdata ({req_y, req_x}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Append or drop the vertex; a restart empties the list and the flag first.
  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt <= '0;
      ovf  <= 1'b0;
    end else if (in_acc && req_func == FUNC_VERTEX) begin
      if (vtx_we) begin
        vcnt <= vtx_base + CW'(1);
      end
      if (req_restart) begin
        ovf <= 1'b0;
      end else if (!vtx_we) begin
        ovf <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Walk: issue one read per cycle, vertex 0 first
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] px, py;

  always_ff @(posedge clk) begin
    if (in_acc && req_func == FUNC_POINT) begin
      px      <= req_x;
      py      <= req_y;
      rd_addr <= '0;
    end else if (rd_en) begin
      rd_addr <= rd_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      rd_first <= 1'b0;
    end else begin
      rd_vld   <= rd_en;
      rd_first <= rd_en && (rd_addr == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Segment stage 1: y straddle and x side tests, differences
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] prev_x, prev_y, cur_x, cur_y;
  logic                seg_v, y_cross, x0_lt, x1_lt, seg_cnt, seg_mul;

  assign cur_x   = rd_data[W-1:0];
  assign cur_y   = rd_data[2*W-1:W];
  assign seg_v   = rd_vld && !rd_first;
  assign y_cross = (prev_y > py) != (cur_y > py);
  assign x0_lt   = prev_x < px;
  assign x1_lt   = cur_x < px;
  assign seg_cnt = y_cross && !x0_lt && !x1_lt;
  assign seg_mul = y_cross && (x0_lt != x1_lt);

  logic                s1_cnt, s1_mul, s1_dypos;
  logic signed [D-1:0] s1_a0, s1_dy, s1_b0, s1_dx;

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    s1_cnt   <= seg_cnt;
    s1_mul   <= seg_mul;
    s1_dypos <= cur_y > prev_y;
    s1_a0    <= $signed({prev_x[W-1], prev_x}) - $signed({px[W-1], px});
    s1_dy    <= $signed({cur_y[W-1], cur_y}) - $signed({prev_y[W-1], prev_y});
    s1_b0    <= $signed({py[W-1], py}) - $signed({prev_y[W-1], prev_y});
    s1_dx    <= $signed({cur_x[W-1], cur_x}) - $signed({prev_x[W-1], prev_x});
  end

  // ---------------------------------------------------------------------------
  // Segment stage 2: cross products, one multiplier per term
  // ---------------------------------------------------------------------------
  logic                s2_cnt, s2_mul, s2_dypos;
  logic signed [P-1:0] s2_pa, s2_pb, pa_next, pb_next;

  assign pa_next = s1_a0 * s1_dy;
  assign pb_next = s1_b0 * s1_dx;

  always_ff @(posedge clk) begin
    s2_cnt   <= s1_cnt;
    s2_mul   <= s1_mul;
    s2_dypos <= s1_dypos;
    s2_pa    <= pa_next;
    s2_pb    <= pb_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= seg_v;
      s2_v <= s1_v;
    end
  end

  // ---------------------------------------------------------------------------
  // Segment stage 3: sign of the sum, corrected by the sign of dy
  // ---------------------------------------------------------------------------
  logic signed [S-1:0] cross_sum;
  logic                sum_neg, sum_zero, seg_hit;

  assign cross_sum = $signed({s2_pa[P-1], s2_pa}) + $signed({s2_pb[P-1], s2_pb});
  assign sum_neg   = cross_sum[S-1];
  assign sum_zero  = (cross_sum == '0);
  assign seg_hit   = s2_cnt ||
                     (s2_mul && (s2_dypos ? !sum_neg : (sum_neg || sum_zero)));

  // Parity of crossings for a lasso walk; box verdict otherwise.
  logic parity;
  logic box_hit;

  assign box_hit = (req_x >= box_lo_x) && (req_x <= box_hi_x) &&
                   (req_y >= box_lo_y) && (req_y <= box_hi_y);

  always_ff @(posedge clk) begin
    if (in_acc && req_func == FUNC_POINT) begin
      parity <= (mode == MODE_BOX) ? box_hit : 1'b0;
    end else if (s2_v && seg_hit) begin
      parity <= ~parity;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {6'b0, ovf, parity ^ invert};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_vcnt_bound: assert property (@(posedge clk) disable iff (rst)
    vcnt <= CW'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_reads_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == ST_WALK || state == ST_DRAIN))
    else $error("vertex read outside a walk");

  a_emit_flag: assert property (@(posedge clk) disable iff (rst)
    emit |=> (m_tvalid && m_tdata[1] == $past(ovf)))
    else $error("truncated field does not match overflow flag");

  a_no_seg_in_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_EMIT) |-> !pipe_busy)
    else $error("segment pipeline busy outside a walk");

endmodule

`default_nettype wire

// File: rtl/pips_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependency on pips_pkg; no imports needed.
`timescale 1ns / 1ps
`default_nettype none

module pips_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
